@@ src/pci_host_bridge_config_space_macros.svh @@
// ----------------------------------------------------------------------------
// Host bridge config space assertion macros
// Shared assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PCI_HOST_BRIDGE_CONFIG_SPACE_MACROS_SVH
`define PCI_HOST_BRIDGE_CONFIG_SPACE_MACROS_SVH

// Check on every rising edge outside reset.
`define PHBCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define PHBCS_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/phbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Host bridge config space package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package phbcs_pkg;

	localparam int BANKS      = 4;
	localparam int BANK_DEPTH = 64;
	localparam int BANK_AW    = 6;
	localparam int NUM_AREAS  = 13;
	localparam int AREA_TOP   = 12;
	localparam int MAX_BYTES  = 4;

	// Byte offsets with special write rules
	localparam logic [7:0] A_CMD_LO     = 8'h04;
	localparam logic [7:0] A_STS_LO     = 8'h06;
	localparam logic [7:0] A_STS_HI     = 8'h07;
	localparam logic [7:0] A_LAT_TMR    = 8'h0D;
	localparam logic [7:0] A_LINE_SIZE  = 8'h0C;
	localparam logic [7:0] A_BIST       = 8'h0F;
	localparam logic [7:0] A_RO_LO      = 8'h10;
	localparam logic [7:0] A_RO_END     = 8'h34;
	localparam logic [7:0] A_CTRL_LO    = 8'h50;
	localparam logic [7:0] A_CTRL_HI    = 8'h51;
	localparam logic [7:0] A_ATTR_TOP   = 8'h59;
	localparam logic [7:0] A_ATTR_FIRST = 8'h5A;
	localparam logic [7:0] A_ATTR_LAST  = 8'h5F;
	localparam logic [4:0] A_DRB_HI5    = 5'h0C;
	localparam logic [7:0] A_SMRAM_RO   = 8'h72;
	localparam logic [7:0] A_ERR_CMD    = 8'h7A;

	// Write masks
	localparam logic [7:0] M_CMD_KEEP   = 8'h40;
	localparam logic [7:0] M_CMD_FORCE  = 8'h06;
	localparam logic [7:0] M_STS_W1C    = 8'hF9;
	localparam logic [7:0] M_LAT_TMR    = 8'hF8;
	localparam logic [7:0] M_CTRL_LO    = 8'h70;
	localparam logic [7:0] M_CTRL_HI    = 8'h8F;
	localparam logic [7:0] M_CTRL_FORCE = 8'h20;
	localparam logic [7:0] M_ERR_WR     = 8'hF5;
	localparam logic [7:0] M_ERR_HOLD   = 8'h0A;

	typedef struct packed {
		logic       active;
		logic       store;
		logic [1:0] idx;
		logic [7:0] addr;
		logic [7:0] wbyte;
		logic [7:0] sbyte;
		logic [7:0] rbyte;
	} lane_t;

	// Power-on contents of the config store
	function automatic logic [7:0] reset_byte(input logic [7:0] addr);
		logic [7:0] v;
		case (addr)
			8'h00:   v = 8'h86;
			8'h01:   v = 8'h80;
			8'h02:   v = 8'h37;
			8'h03:   v = 8'h12;
			8'h04:   v = 8'h06;
			8'h06:   v = 8'h80;
			8'h07:   v = 8'h02;
			8'h0B:   v = 8'h06;
			8'h51:   v = 8'h01;
			8'h58:   v = 8'h10;
			8'h72:   v = 8'h02;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Byte address served by a bank for an access starting at off; bit 8 marks wrap
	function automatic logic [8:0] bank_addr(input logic [7:0] off, input logic [1:0] bank);
		logic [1:0] lane;
		lane = bank - off[1:0];
		return {1'b0, off} + {7'd0, lane};
	endfunction

endpackage

@@ src/phbcs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module phbcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/phbcs_lane.sv @@
// ----------------------------------------------------------------------------
// Config space byte lane
// Decodes one bank's byte of an access and applies its write rule.
// ----------------------------------------------------------------------------
module phbcs_lane (
	input  logic              [1:0]  bank,
	input  logic                     kind,
	input  logic              [7:0]  offset,
	input  logic              [2:0]  byte_count,
	input  logic              [31:0] write_data,
	input  logic                     old_valid,
	input  logic              [7:0]  rdata,
	output phbcs_pkg::lane_t         lane
);

	logic [8:0] addr9;
	logic [1:0] idx;
	logic [2:0] cnt;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] old;
	logic       active;
	logic       keep;
	logic [7:0] sbyte;

	assign addr9  = phbcs_pkg::bank_addr(offset, bank);
	assign idx    = bank - offset[1:0];
	assign a      = addr9[7:0];
	assign cnt    = (byte_count > 3'(phbcs_pkg::MAX_BYTES)) ? 3'(phbcs_pkg::MAX_BYTES)
	                                                         : byte_count;
	assign active = ({1'b0, idx} < cnt) && !addr9[8];
	assign b      = write_data[8*idx +: 8];
	// unwritten entries read as their power-on value
	assign old    = old_valid ? rdata : phbcs_pkg::reset_byte(a);

	always_comb begin
		keep  = 1'b1;
		sbyte = b;
		if (a >= phbcs_pkg::A_RO_LO && a < phbcs_pkg::A_RO_END) begin
			keep = 1'b0;
		end else begin
			case (a)
				phbcs_pkg::A_CMD_LO:
					sbyte = (b & phbcs_pkg::M_CMD_KEEP) | phbcs_pkg::M_CMD_FORCE;
				phbcs_pkg::A_STS_HI:
					sbyte = old & ~(b & phbcs_pkg::M_STS_W1C);
				phbcs_pkg::A_LAT_TMR:
					sbyte = b & phbcs_pkg::M_LAT_TMR;
				phbcs_pkg::A_STS_LO, phbcs_pkg::A_LINE_SIZE,
				phbcs_pkg::A_BIST, phbcs_pkg::A_SMRAM_RO:
					keep = 1'b0;
				phbcs_pkg::A_CTRL_LO:
					sbyte = b & phbcs_pkg::M_CTRL_LO;
				phbcs_pkg::A_CTRL_HI:
					sbyte = (b & phbcs_pkg::M_CTRL_HI) | phbcs_pkg::M_CTRL_FORCE;
				phbcs_pkg::A_ERR_CMD:
					sbyte = (old & phbcs_pkg::M_ERR_HOLD) | (b & phbcs_pkg::M_ERR_WR);
				default:
					sbyte = b;
			endcase
		end
	end

	assign lane.active = active;
	assign lane.store  = kind && active && keep;
	assign lane.idx    = idx;
	assign lane.addr   = a;
	assign lane.wbyte  = b;
	assign lane.sbyte  = sbyte;
	assign lane.rbyte  = old;

endmodule

@@ src/pci_host_bridge_config_space.sv @@
// ----------------------------------------------------------------------------
// Host bridge configuration space
// Flow: an accepted access is held in s1 while the banks read, and its result
// is registered into the output register once that frees. The next access is
// not taken until the write-back of the current one completes.
// Reset: async, clears enables, row flags and store valid bits at once.
// ----------------------------------------------------------------------------
module pci_host_bridge_config_space #(
	parameter int DRAM_ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // offset[7:0], write_data[39:8], byte_count[42:40], zero pad
	input  logic [0:0]  s_tuser,   // kind[0]: 0 read, 1 write
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // read_data[31:0], area_read_enable[44:32],
	                               // area_write_enable[57:45], row_mismatch[65:58], zero pad
	// DRAM row boundary register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int NA = phbcs_pkg::NUM_AREAS;

	// The store is split into four banks by the low two address bits, so the
	// up-to-four bytes of one access always land in distinct banks.

	logic                      v_s1;
	logic                      kind_s1;
	logic [7:0]                offset_s1;
	logic [31:0]               wdata_s1;
	logic [2:0]                count_s1;

	logic [7:0]                drb_q;
	logic [NA-1:0]             ren_q;
	logic [NA-1:0]             wen_q;
	logic [DRAM_ROWS-1:0]      rows_q;
	logic [phbcs_pkg::BANKS-1:0][phbcs_pkg::BANK_DEPTH-1:0] valid_q;

	logic                      out_valid_q;
	logic [71:0]               out_data_q;

	logic                      accept;
	logic                      done;
	logic [NA-1:0]             ren_d;
	logic [NA-1:0]             wen_d;
	logic [DRAM_ROWS-1:0]      rows_d;
	logic [7:0]                rows_out;
	logic [31:0]               rd;

	phbcs_pkg::lane_t          lane   [phbcs_pkg::BANKS];
	logic [7:0]                rdata  [phbcs_pkg::BANKS];
	logic [8:0]                raddr9 [phbcs_pkg::BANKS];

	// Hold an access in s1 while the banks read; finish when the output frees.
	assign s_tready  = !v_s1;
	assign accept    = s_tvalid && s_tready;
	assign done      = v_s1 && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	for (genvar k = 0; k < phbcs_pkg::BANKS; k++) begin : g_bank
		assign raddr9[k] = phbcs_pkg::bank_addr(s_tdata[7:0], 2'(k));

		phbcs_ram #(
			.WIDTH(8),
			.DEPTH(phbcs_pkg::BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (done && lane[k].store),
			.waddr (lane[k].addr[7:2]),
			.wdata (lane[k].sbyte),
			.re    (accept),
			.raddr (raddr9[k][7:2]),
			.rdata (rdata[k])
		);

		phbcs_lane u_lane (
			.bank       (2'(k)),
			.kind       (kind_s1),
			.offset     (offset_s1),
			.byte_count (count_s1),
			.write_data (wdata_s1),
			.old_valid  (valid_q[k][lane[k].addr[7:2]]),
			.rdata      (rdata[k]),
			.lane       (lane[k])
		);
	end

	// Gather read bytes into their lanes; update enables and row flags.
	always_comb begin
		logic [2:0] n;
		rd     = '0;
		ren_d  = ren_q;
		wen_d  = wen_q;
		rows_d = rows_q;
		for (int k = 0; k < phbcs_pkg::BANKS; k++) begin
			n = 3'(lane[k].addr - phbcs_pkg::A_ATTR_FIRST);
			if (lane[k].active && !kind_s1) begin
				rd[8*lane[k].idx +: 8] = lane[k].rbyte;
			end
			if (lane[k].store) begin
				if (lane[k].addr == phbcs_pkg::A_ATTR_TOP) begin
					ren_d[phbcs_pkg::AREA_TOP] = lane[k].wbyte[4];
					wen_d[phbcs_pkg::AREA_TOP] = lane[k].wbyte[5];
				end else if (lane[k].addr >= phbcs_pkg::A_ATTR_FIRST &&
				             lane[k].addr <= phbcs_pkg::A_ATTR_LAST) begin
					ren_d[{n, 1'b0}] = lane[k].wbyte[0];
					wen_d[{n, 1'b0}] = lane[k].wbyte[1];
					ren_d[{n, 1'b1}] = lane[k].wbyte[4];
					wen_d[{n, 1'b1}] = lane[k].wbyte[5];
				end
				if (lane[k].addr[7:3] == phbcs_pkg::A_DRB_HI5) begin
					for (int r = 0; r < DRAM_ROWS; r++) begin
						if (lane[k].addr[2:0] == 3'(r)) begin
							rows_d[r] = (lane[k].wbyte != drb_q);
						end
					end
				end
			end
		end
		rows_out = '0;
		for (int r = 0; r < DRAM_ROWS; r++) begin
			rows_out[r] = rows_d[r];
		end
	end

	// Capture the accepted beat; register the result when the access finishes.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= s_tuser[0];
			offset_s1 <= s_tdata[7:0];
			wdata_s1  <= s_tdata[39:8];
			count_s1  <= s_tdata[42:40];
		end
		if (done) begin
			out_data_q <= {6'd0, rows_out, wen_d, ren_d, rd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			drb_q       <= '0;
			ren_q       <= '0;
			wen_q       <= '0;
			rows_q      <= '0;
			valid_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				drb_q <= cfg_data;
			end
			// advance s1: set on accept, drop when the write-back completes
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (done) begin
				v_s1 <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
				ren_q       <= ren_d;
				wen_q       <= wen_d;
				rows_q      <= rows_d;
				for (int k = 0; k < phbcs_pkg::BANKS; k++) begin
					if (lane[k].store) begin
						valid_q[k][lane[k].addr[7:2]] <= 1'b1;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/phbcs_checker.sv @@
// ----------------------------------------------------------------------------
// Host bridge config space port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "pci_host_bridge_config_space_macros.svh"

module phbcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// An accepted beat holds off the next one for the write-back cycle.
	`PHBCS_ASSERT(a_interlock, s_tvalid && s_tready |=> !s_tready, "input taken during write-back")

	// A fresh result is offered only after its beat has been accepted and held in s1.
	`PHBCS_ASSERT(a_fresh_result, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without access")

	// A write returns no read data.
	`PHBCS_ASSERT(a_write_no_data, $rose(m_tvalid) && $past(s_tuser[0], 2) |-> m_tdata[31:0] == 32'd0, "write returned data")

	// A stalled result holds.
	`PHBCS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// Reset clears any offered result.
	`PHBCS_ASSERT_RST(a_reset_idle, !arst_n |=> !m_tvalid, "result during reset")

endmodule

bind pci_host_bridge_config_space phbcs_checker u_phbcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/pci_host_bridge_config_space_tb.sv @@
// ----------------------------------------------------------------------------
// Host bridge configuration space testbench
// Streams read and write accesses into the config space block and checks
// every result beat against a cycle-free model of the store, the memory-area
// enables and the DRAM row mismatch flags. The row boundary register is
// reprogrammed between traffic phases, both sides idle at random, and one
// stretch of the run keeps both sides busy on every cycle.
// ----------------------------------------------------------------------------
module pci_host_bridge_config_space_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAM_ROWS        = 8;
	localparam int IDLE_PCT         = 19;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int PHASES           = 5;
	localparam int STALL_LIMIT      = 5000;
	localparam int QUIET_FROM       = 1200;
	localparam int QUIET_TO         = 2400;
	localparam int DRAIN_CYCLES     = 8;
	localparam int REPORT_CAP       = 40;
	localparam logic [7:0] ROW_MASK = 8'((1 << DRAM_ROWS) - 1);

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [2:0]  count;
	} access_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic [12:0] rd_en;
		logic [12:0] wr_en;
		logic [7:0]  rows;
	} status_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // offset[7:0], write_data[39:8], byte_count[42:40], zero pad
	logic [0:0]  s_tuser   = '0;   // kind[0]: 0 read, 1 write
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;          // read_data[31:0], area_read_enable[44:32],
	                               // area_write_enable[57:45], row_mismatch[65:58], zero pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// Model state: config store, area enables, row flags and the boundary register
	logic [7:0]  space_bytes [256];
	logic [12:0] rd_en_bits;
	logic [12:0] wr_en_bits;
	logic [7:0]  row_flags;
	logic [7:0]  row_boundary;

	access_t access_q [$];          // accesses waiting to be driven
	status_t pending_results [$];   // results owed by accepted accesses
	access_t in_flight;             // access currently offered on the slave side

	int   cycle_no    = 0;
	int   idle_cycles = 0;
	int   fault_count = 0;
	logic quiet;

	// Hold both sides busy on every cycle inside this window
	assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

	pci_host_bridge_config_space #(
		.DRAM_ROWS(DRAM_ROWS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// Power-on image of the store, enables and flags
	function automatic void clear_model();
		foreach (space_bytes[i])
			space_bytes[i] = 8'h00;
		space_bytes[8'h00] = 8'h86;
		space_bytes[8'h01] = 8'h80;
		space_bytes[8'h02] = 8'h37;
		space_bytes[8'h03] = 8'h12;
		space_bytes[8'h04] = 8'h06;
		space_bytes[8'h06] = 8'h80;
		space_bytes[8'h07] = 8'h02;
		space_bytes[8'h0B] = 8'h06;
		space_bytes[8'h51] = 8'h01;
		space_bytes[8'h58] = 8'h10;
		space_bytes[8'h72] = 8'h02;
		rd_en_bits   = '0;
		wr_en_bits   = '0;
		row_flags    = '0;
		row_boundary = '0;
	endfunction

	// Bit 0 of the pair is the read enable, bit 1 the write enable
	function automatic void load_area(input int area, input logic [1:0] pair);
		if (area < phbcs_pkg::NUM_AREAS) begin
			rd_en_bits[area] = pair[0];
			wr_en_bits[area] = pair[1];
		end
	endfunction

	// Apply one written byte lane according to the rule of its offset
	function automatic void store_byte(input logic [7:0] a, input logic [7:0] b);
		int pair_idx;
		if (a >= phbcs_pkg::A_RO_LO && a < phbcs_pkg::A_RO_END)
			return;
		// DRAM row boundary bytes: store and compare with the expected boundary
		if (a[7:3] == phbcs_pkg::A_DRB_HI5) begin
			space_bytes[a] = b;
			if (int'(a[2:0]) < DRAM_ROWS)
				row_flags[a[2:0]] = (b != row_boundary);
			return;
		end
		// Attribute bytes carry two areas each: low nibble and high nibble
		if (a >= phbcs_pkg::A_ATTR_FIRST && a <= phbcs_pkg::A_ATTR_LAST) begin
			pair_idx = int'(a - phbcs_pkg::A_ATTR_FIRST);
			space_bytes[a] = b;
			load_area(2 * pair_idx, b[1:0]);
			load_area(2 * pair_idx + 1, b[5:4]);
			return;
		end
		case (a)
			phbcs_pkg::A_CMD_LO:
				space_bytes[a] = (b & phbcs_pkg::M_CMD_KEEP) | phbcs_pkg::M_CMD_FORCE;
			phbcs_pkg::A_STS_HI:
				space_bytes[a] = space_bytes[a] & ~(b & phbcs_pkg::M_STS_W1C);
			phbcs_pkg::A_LAT_TMR:
				space_bytes[a] = b & phbcs_pkg::M_LAT_TMR;
			phbcs_pkg::A_STS_LO, phbcs_pkg::A_LINE_SIZE,
			phbcs_pkg::A_BIST, phbcs_pkg::A_SMRAM_RO: ;
			phbcs_pkg::A_CTRL_LO:
				space_bytes[a] = b & phbcs_pkg::M_CTRL_LO;
			phbcs_pkg::A_CTRL_HI:
				space_bytes[a] = (b & phbcs_pkg::M_CTRL_HI) | phbcs_pkg::M_CTRL_FORCE;
			phbcs_pkg::A_ATTR_TOP: begin
				space_bytes[a] = b;
				load_area(phbcs_pkg::AREA_TOP, b[5:4]);
			end
			phbcs_pkg::A_ERR_CMD:
				space_bytes[a] = (space_bytes[a] & phbcs_pkg::M_ERR_HOLD) |
				                 (b & phbcs_pkg::M_ERR_WR);
			default:
				space_bytes[a] = b;
		endcase
	endfunction

	// Perform one access on the model and return the result it must produce
	function automatic status_t bridge_access(input access_t acc);
		status_t res;
		int      lanes;
		int      a;
		res   = '0;
		lanes = (acc.count > 3'd4) ? 4 : int'(acc.count);
		for (int i = 0; i < lanes; i++) begin
			a = int'(acc.offset) + i;
			// Lanes past the top of the space are dropped
			if (a > 255)
				break;
			if (acc.kind == KIND_WRITE)
				store_byte(a[7:0], acc.wdata[8*i +: 8]);
			else
				res.rdata[8*i +: 8] = space_bytes[a];
		end
		res.rd_en = rd_en_bits;
		res.wr_en = wr_en_bits;
		res.rows  = row_flags & ROW_MASK;
		return res;
	endfunction

	function automatic void push_access(input logic kind, input logic [7:0] off,
	                                    input logic [31:0] data, input logic [2:0] cnt);
		access_t acc;
		acc.kind   = kind;
		acc.offset = off;
		acc.wdata  = data;
		acc.count  = cnt;
		access_q.push_back(acc);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= REPORT_CAP)
				$error("%s: expected %h, got %h", name, want, got);
		end
	endfunction

	// ------------------------------------------------------------------
	// Slave-side driver: offer queued accesses, predict on each accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(bridge_access(in_flight));
			// Advance only when nothing is offered or the offered beat just went through
			if (!s_tvalid || s_tready) begin
				if (access_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					in_flight = access_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {5'd0, in_flight.count, in_flight.wdata, in_flight.offset};
					s_tuser  <= in_flight.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Master-side monitor: random backpressure, compare each result beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		status_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_CAP)
						$error("result beat with no access outstanding: %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					check_field("read_data", want.rdata, m_tdata[31:0]);
					check_field("area_read_enable", 32'(want.rd_en), 32'(m_tdata[44:32]));
					check_field("area_write_enable", 32'(want.wr_en), 32'(m_tdata[57:45]));
					check_field("row_mismatch", 32'(want.rows), 32'(m_tdata[65:58]));
				end
			end
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: drop the run when no beat moves on any channel for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("[pci_host_bridge_config_space] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Wait until every queued access is accepted and every result is back
	task automatic wait_for_drain();
		while (access_q.size() > 0 || pending_results.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the row boundary register; call only while the block is idle
	task automatic program_boundary(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid   <= 1'b0;
		row_boundary = value;
	endtask

	// ------------------------------------------------------------------
	// Stimulus: reset, then phases of traffic under different boundaries
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] boundary_plan [PHASES];
		access_t    acc;
		int         pick;
		int         off;
		int         odd;

		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Cover both extremes of the boundary, plus two random values
		boundary_plan[0] = 8'h00;
		boundary_plan[1] = 8'hFF;
		boundary_plan[2] = 8'($urandom);
		boundary_plan[3] = 8'($urandom_range(254, 1));
		boundary_plan[4] = 8'h00;

		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			program_boundary(boundary_plan[p]);

			if (p == 0) begin
				// Directed pass with the boundary at zero
				push_access(KIND_READ,  8'h00, 32'h0000_0000, 3'd4);  // identity bytes
				push_access(KIND_WRITE, 8'h04, 32'hFFFF_FFFF, 3'd4);  // command, status W1C
				push_access(KIND_READ,  8'h04, 32'h0000_0000, 3'd4);
				push_access(KIND_WRITE, 8'h0C, 32'hFFFF_FFFF, 3'd4);  // line size RO, latency mask
				push_access(KIND_READ,  8'h0C, 32'h0000_0000, 3'd4);
				push_access(KIND_WRITE, 8'h0E, 32'hA5A5_A5A5, 3'd4);  // into the read-only window
				push_access(KIND_WRITE, 8'h32, 32'h1122_3344, 3'd4);  // across the window end
				push_access(KIND_READ,  8'h30, 32'h0000_0000, 3'd4);
				push_access(KIND_READ,  8'h34, 32'h0000_0000, 3'd4);
				push_access(KIND_WRITE, 8'h50, 32'h0000_FFFF, 3'd2);  // control masks and force
				push_access(KIND_READ,  8'h50, 32'h0000_0000, 3'd2);
				push_access(KIND_WRITE, 8'h59, 32'hFFFF_FFFF, 3'd4);  // top attribute byte and areas 0 to 5 on
				push_access(KIND_WRITE, 8'h5D, 32'hFFFF_FFFF, 3'd4);  // attributes into row 0
				push_access(KIND_WRITE, 8'h5A, 32'h3021_1203, 3'd4);  // mixed enable pairs
				push_access(KIND_WRITE, 8'h60, 32'h0000_0000, 3'd4);  // rows match the boundary
				push_access(KIND_WRITE, 8'h64, 32'h0403_0201, 3'd4);  // rows differ
				push_access(KIND_READ,  8'h60, 32'h0000_0000, 3'd4);
				push_access(KIND_WRITE, 8'h72, 32'h0000_00FF, 3'd1);  // read-only SMRAM byte
				push_access(KIND_WRITE, 8'h7A, 32'h0000_00FF, 3'd1);  // error command mask
				push_access(KIND_WRITE, 8'h7A, 32'h0000_0000, 3'd1);
				push_access(KIND_READ,  8'h78, 32'h0000_0000, 3'd4);
				push_access(KIND_WRITE, 8'hFE, 32'hDEAD_BEEF, 3'd4);  // lanes past the top
				push_access(KIND_READ,  8'hFC, 32'h0000_0000, 3'd4);
				push_access(KIND_READ,  8'hFF, 32'h0000_0000, 3'd7);
				push_access(KIND_READ,  8'h00, 32'hFFFF_FFFF, 3'd0);  // zero-length access
				push_access(KIND_WRITE, 8'h80, 32'h1234_5678, 3'd0);
				push_access(KIND_WRITE, 8'h80, 32'hCAFE_F00D, 3'd5);  // oversize counts clamp
				push_access(KIND_READ,  8'h80, 32'h0000_0000, 3'd6);
			end

			// Random traffic, weighted toward the offsets with special rules
			repeat (RANDOM_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 35)
					off = $urandom_range(8'h12, 8'h00);
				else if (pick < 60)
					off = $urandom_range(8'h6A, 8'h4E);
				else if (pick < 70)
					off = $urandom_range(8'h7C, 8'h70);
				else if (pick < 78)
					off = $urandom_range(8'h36, 8'h2E);
				else if (pick < 85)
					off = $urandom_range(8'hFF, 8'hF8);
				else
					off = $urandom_range(255);
				acc.offset = 8'(off);
				acc.kind   = ($urandom_range(99) < 55) ? KIND_WRITE : KIND_READ;
				acc.wdata  = $urandom;
				if ($urandom_range(99) < 95) begin
					acc.count = 3'($urandom_range(4, 1));
				end else begin
					odd       = $urandom_range(3);
					acc.count = (odd == 0) ? 3'd0 : 3'(odd + 4);
				end
				// Half of the row boundary lanes match, so flags clear as well as set
				for (int i = 0; i < 4; i++)
					if (((off + i) >> 3) == int'(phbcs_pkg::A_DRB_HI5) &&
					    $urandom_range(1) == 1)
						acc.wdata[8*i +: 8] = row_boundary;
				access_q.push_back(acc);
			end
		end

		wait_for_drain();
		if (fault_count == 0)
			$display("[pci_host_bridge_config_space] OK");
		else
			$display("[pci_host_bridge_config_space] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/phbcs_pkg.sv
src/phbcs_ram.sv
src/phbcs_lane.sv
src/pci_host_bridge_config_space.sv
src/phbcs_checker.sv
tb/pci_host_bridge_config_space_tb.sv
